// ===== rtl/bpc_pkg.sv =====
package bpc_pkg;

	// timestamp width; elapsed time wraps modulo 2^TIME_BITS
	localparam int TIME_BITS = 32;
	localparam int CFG_BITS  = 16;

	// register reset values
	localparam logic [CFG_BITS-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_BITS-1:0] LONG_RST     = 16'd1000;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_DEBOUNCE = 1'b0,
		REG_LONG     = 1'b1
	} bpc_reg_t;

	// thresholds shared by all button units
	typedef struct packed {
		logic [CFG_BITS-1:0] debounce_ms;
		logic [CFG_BITS-1:0] long_press_ms;
	} bpc_cfg_t;

	// one poll sample
	typedef struct packed {
		logic                 mode_level;
		logic                 plus_level;
		logic                 minus_level;
		logic [TIME_BITS-1:0] time_ms;
	} bpc_in_t;

	// events of one sample
	typedef struct packed {
		logic mode_short;
		logic mode_long;
		logic plus_step;
		logic minus_step;
	} bpc_out_t;

endpackage

// ===== rtl/button_press_classifier.sv =====
// Button press classifier: takes one poll sample per beat (three raw button
// levels and a wrapping millisecond timestamp) and returns exactly one event
// beat per sample. The block accepts a sample every clock cycle unless
// in_stall is high; each sample passes from the input register through the
// single pass of compare logic into the result register. Stalls on the result
// side back up through the input register. Write the thresholds
// through the configuration port only while no sample is in flight.
module button_press_classifier import bpc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  bpc_in_t             in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output bpc_out_t            out_data
);

	bpc_cfg_t             cfg_q;
	logic                 valid_s1;
	bpc_in_t              data_s1;
	logic                 adv;
	logic                 out_free;
	logic                 mode_held_q;
	logic                 mode_done_q;
	logic [TIME_BITS-1:0] mode_since_q;
	logic [TIME_BITS-1:0] mode_since_eff;
	logic [TIME_BITS-1:0] mode_elapsed;
	logic                 plus_step;
	logic                 minus_step;
	bpc_out_t             res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.long_press_ms <= LONG_RST;
		end else if (cfg_we) begin
			unique case (bpc_reg_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce_ms   <= cfg_data;
				REG_LONG:     cfg_q.long_press_ms <= cfg_data;
				default:      ;
			endcase
		end
	end

	// flow control
	assign out_free = !out_valid || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	// mode button: one long event while held, short event on release
	assign mode_since_eff = (data_s1.mode_level && !mode_held_q) ? data_s1.time_ms
	                                                             : mode_since_q;
	assign mode_elapsed   = data_s1.time_ms - mode_since_eff;

	always_comb begin
		res.mode_short = 1'b0;
		res.mode_long  = 1'b0;
		res.plus_step  = plus_step;
		res.minus_step = minus_step;
		if (data_s1.mode_level) begin
			res.mode_long = !mode_done_q
				&& (mode_elapsed >= TIME_BITS'(cfg_q.long_press_ms));
		end else begin
			res.mode_short = mode_held_q && !mode_done_q
				&& (mode_elapsed >= TIME_BITS'(cfg_q.debounce_ms));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_held_q  <= 1'b0;
			mode_done_q  <= 1'b0;
			mode_since_q <= '0;
		end else if (adv) begin
			mode_held_q  <= data_s1.mode_level;
			mode_done_q  <= data_s1.mode_level && (mode_done_q || res.mode_long);
			mode_since_q <= mode_since_eff;
		end
	end

	// plus and minus buttons with auto-repeat
	bpc_step u_plus (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv),
		.level   (data_s1.plus_level),
		.now     (data_s1.time_ms),
		.cfg     (cfg_q),
		.step    (plus_step)
	);

	bpc_step u_minus (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv),
		.level   (data_s1.minus_level),
		.now     (data_s1.time_ms),
		.cfg     (cfg_q),
		.step    (minus_step)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data <= res;
		end
	end

	// short and long events of the mode button never share a beat
	a_mode_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.mode_short && out_data.mode_long))
		else $error("mode short and long in one beat");

	// a long event is only remembered while the button is held
	a_done_held: assert property (@(posedge clk) disable iff (!arst_n)
		mode_done_q |-> mode_held_q)
		else $error("mode done without held");

	// the input side stalls only behind an occupied input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// a sample that leaves the input register shows up as a result
	a_adv_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid)
		else $error("advanced sample lost");

endmodule

// ===== rtl/bpc_step.sv =====
module bpc_step import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic                 level,
	input  logic [TIME_BITS-1:0] now,
	input  bpc_cfg_t             cfg,
	output logic                 step
);

	logic                 held_q;
	logic [TIME_BITS-1:0] since_q;
	logic [TIME_BITS-1:0] since_eff;
	logic [TIME_BITS-1:0] elapsed;

	// a fresh press starts timing at this sample
	assign since_eff = (level && !held_q) ? now : since_q;
	assign elapsed   = now - since_eff;

	// auto-repeat while held, one more step on a debounced release
	always_comb begin
		if (level) begin
			step = (elapsed >= TIME_BITS'(cfg.long_press_ms));
		end else begin
			step = held_q && (elapsed >= TIME_BITS'(cfg.debounce_ms));
		end
	end

	// press tracking, updated as the sample leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			since_q <= '0;
		end else if (advance) begin
			held_q  <= level;
			since_q <= since_eff;
		end
	end

endmodule
